// ----- rtl/segment_table_heap_allocator_macros.svh -----
// Assertion macros shared by the segment table heap allocator RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef SEGMENT_TABLE_HEAP_ALLOCATOR_MACROS_SVH
`define SEGMENT_TABLE_HEAP_ALLOCATOR_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, checked at every rising edge outside reset.
`define STHA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("stha assertion failed");
// Next-cycle implication, checked at every rising edge outside reset.
`define STHA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("stha assertion failed");
`else
`define STHA_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define STHA_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/stha_pkg.sv -----
// Shared types and constants of the segment table heap allocator.
// Depends on nothing; used by the interfaces, the controller, the datapath and the top level.
package stha_pkg;

    // Fixed widths of the item fields.
    localparam int FIELD_W  = 17;
    localparam int STATUS_W = 2;
    // A rounded request size can reach 2^17, so it needs one bit more.
    localparam int SIZE_W   = FIELD_W + 1;

    // Defaults for the top-level parameters.
    localparam int HEAP_BYTES_DEF    = 65536;
    localparam int TABLE_ENTRIES_DEF = 32;

    // Operation codes.
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK       = 2'd0,
        STATUS_NOMEM    = 2'd1,
        STATUS_NOTALLOC = 2'd2
    } status_t;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ALLOC,
        ST_SCAN,
        ST_FINISH
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start;
        logic do_alloc;
        logic scan_step;
        logic commit_free;
        logic load_out;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_done;
        logic out_free;
    } stat_t;

endpackage

// ----- rtl/stha_req_if.sv -----
// Request channel of the segment table heap allocator.
// Depends on stha_pkg for the field widths.
interface stha_req_if;
    logic                        valid;
    logic                        ready;
    logic                        opcode;
    logic [stha_pkg::FIELD_W-1:0] request_size;
    logic [stha_pkg::FIELD_W-1:0] free_offset;

    modport source (output valid, output opcode, output request_size, output free_offset,
                    input ready);
    modport sink (input valid, input opcode, input request_size, input free_offset,
                  output ready);
endinterface

// ----- rtl/stha_rsp_if.sv -----
// Result channel of the segment table heap allocator.
// Depends on stha_pkg for the field widths.
interface stha_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [stha_pkg::FIELD_W-1:0]  alloc_offset;
    logic [stha_pkg::STATUS_W-1:0] status;
    logic [stha_pkg::FIELD_W-1:0]  used_bytes;

    modport source (output valid, output alloc_offset, output status, output used_bytes,
                    input ready);
    modport sink (input valid, input alloc_offset, input status, input used_bytes,
                  output ready);
endinterface

// ----- rtl/stha_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; holds the segment table.
module stha_ram #(
    parameter int WIDTH = 34,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/stha_ctrl.sv -----
// Controller state machine of the segment table heap allocator.
// Depends on stha_pkg for the state, command and status types.
`include "segment_table_heap_allocator_macros.svh"
module stha_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic            opcode,
    output logic            in_ready,
    input  stha_pkg::stat_t stat,
    output stha_pkg::cmd_t  cmd
);

    stha_pkg::state_t state_reg;
    stha_pkg::state_t state_next;
    logic             in_fire;

    assign in_fire = in_valid && in_ready;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= stha_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            stha_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = (opcode == stha_pkg::OP_ALLOC) ? stha_pkg::ST_ALLOC
                                                                : stha_pkg::ST_SCAN;
                end
            end
            stha_pkg::ST_ALLOC:
            begin
                state_next = stha_pkg::ST_FINISH;
            end
            stha_pkg::ST_SCAN:
            begin
                if (stat.scan_done)
                begin
                    state_next = stha_pkg::ST_FINISH;
                end
            end
            stha_pkg::ST_FINISH:
            begin
                if (stat.out_free)
                begin
                    state_next = stha_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = stha_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs.
    always_comb
    begin
        in_ready        = 1'b0;
        cmd             = '0;
        case (state_reg)
            stha_pkg::ST_IDLE:
            begin
                in_ready  = 1'b1;
                cmd.start = in_valid;
            end
            stha_pkg::ST_ALLOC:
            begin
                cmd.do_alloc = 1'b1;
            end
            stha_pkg::ST_SCAN:
            begin
                cmd.scan_step   = !stat.scan_done;
                cmd.commit_free = stat.scan_done;
            end
            stha_pkg::ST_FINISH:
            begin
                cmd.load_out = stat.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // A finished scan always hands over to the result stage, and items are taken only when idle.
    `STHA_ASSERT_NXT(a_scan_reaches_finish, clk, rst_n,
                     state_reg == stha_pkg::ST_SCAN && stat.scan_done,
                     state_reg == stha_pkg::ST_FINISH)
    `STHA_ASSERT_IMP(a_one_command, clk, rst_n, 1'b1, $onehot0(cmd))
    `STHA_ASSERT_IMP(a_ready_only_idle, clk, rst_n, in_ready, state_reg == stha_pkg::ST_IDLE)

endmodule

// ----- rtl/stha_dp.sv -----
// Datapath of the segment table heap allocator: table RAM, heap end,
// segment count, free scan pipeline and output register.
// Depends on stha_pkg and stha_ram.
`include "segment_table_heap_allocator_macros.svh"
module stha_dp #(
    parameter int HEAP_BYTES    = stha_pkg::HEAP_BYTES_DEF,
    parameter int TABLE_ENTRIES = stha_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  stha_pkg::cmd_t                 cmd,
    output stha_pkg::stat_t                stat,
    input  logic [stha_pkg::FIELD_W-1:0]   request_size,
    input  logic [stha_pkg::FIELD_W-1:0]   free_offset,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [stha_pkg::FIELD_W-1:0]   alloc_offset,
    output logic [stha_pkg::STATUS_W-1:0]  status,
    output logic [stha_pkg::FIELD_W-1:0]   used_bytes
);

    localparam int OFF_W  = $clog2(HEAP_BYTES + 1);
    localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
    localparam int ADDR_W = $clog2(TABLE_ENTRIES);
    localparam int CMP_W  = (OFF_W > stha_pkg::FIELD_W) ? OFF_W : stha_pkg::FIELD_W;
    localparam int SUM_W  = ((OFF_W > stha_pkg::SIZE_W) ? OFF_W : stha_pkg::SIZE_W) + 1;
    localparam int ENT_W  = 2 * OFF_W;

    // Control state.
    logic [CNT_W-1:0]          count_reg, count_next;
    logic [OFF_W-1:0]          used_reg, used_next;
    logic [CNT_W-1:0]          scan_cnt_reg, scan_cnt_next;
    logic                      pend_reg, pend_next;
    logic                      found_reg, found_next;
    logic                      out_valid_reg, out_valid_next;

    // Payload registers.
    logic [stha_pkg::FIELD_W-1:0] size_reg, size_next;
    logic [stha_pkg::FIELD_W-1:0] off_reg, off_next;
    logic [ADDR_W-1:0]            pend_idx_reg, pend_idx_next;
    logic [OFF_W-1:0]             keep_end_reg, keep_end_next;
    logic [stha_pkg::FIELD_W-1:0] res_offset_reg, res_offset_next;
    stha_pkg::status_t            res_status_reg, res_status_next;
    logic [stha_pkg::FIELD_W-1:0] out_offset_reg, out_offset_next;
    stha_pkg::status_t            out_status_reg, out_status_next;
    logic [stha_pkg::FIELD_W-1:0] out_used_reg, out_used_next;

    // RAM ports; an entry holds the start and the end offset of a segment.
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [ENT_W-1:0]  ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [ENT_W-1:0]  ram_rdata;
    logic [OFF_W-1:0]  rd_start;
    logic [OFF_W-1:0]  rd_end;

    // Allocate arithmetic.
    logic [stha_pkg::SIZE_W-1:0]  size_plus;
    logic [stha_pkg::SIZE_W-1:0]  size_round;
    logic [SUM_W-1:0]             new_end;
    logic                         alloc_fail;
    logic [CMP_W-1:0]             used_wide;
    logic [stha_pkg::FIELD_W-1:0] used_field;
    logic [CMP_W-1:0]             next_wide;

    // Scan signals.
    logic scan_issue;
    logic scan_match;

    stha_ram #(
        .WIDTH(ENT_W),
        .DEPTH(TABLE_ENTRIES)
    ) u_table (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign rd_start = ram_rdata[ENT_W-1:OFF_W];
    assign rd_end   = ram_rdata[OFF_W-1:0];

    // Round the request up to a multiple of four and check it against heap and table.
    assign size_plus  = stha_pkg::SIZE_W'(size_reg) + stha_pkg::SIZE_W'(3);
    assign size_round = {size_plus[stha_pkg::SIZE_W-1:2], 2'b00};
    assign new_end    = SUM_W'(used_reg) + SUM_W'(size_round);
    assign alloc_fail = (new_end > SUM_W'(HEAP_BYTES)) || (count_reg >= CNT_W'(TABLE_ENTRIES));
    assign used_wide  = CMP_W'(used_reg);
    assign used_field = used_wide[stha_pkg::FIELD_W-1:0];

    // The scan reads one entry a cycle; its data is checked in the cycle after the read.
    assign scan_issue = cmd.scan_step && (scan_cnt_reg < count_reg);
    assign scan_match = !found_reg && (CMP_W'(rd_start) == CMP_W'(off_reg));
    assign ram_raddr  = scan_cnt_reg[ADDR_W-1:0];

    assign stat.scan_done = !pend_reg && (scan_cnt_reg >= count_reg);
    assign stat.out_free  = !out_valid_reg || out_ready;

    // RAM write: append on allocate, move an entry down one place after a match.
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = count_reg[ADDR_W-1:0];
        ram_wdata = {used_reg, new_end[OFF_W-1:0]};
        if (cmd.do_alloc)
        begin
            ram_we = !alloc_fail;
        end
        else if (pend_reg && found_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = pend_idx_reg - ADDR_W'(1);
            ram_wdata = ram_rdata;
        end
    end

    // Next values of state and result registers.
    always_comb
    begin
        count_next      = count_reg;
        used_next       = used_reg;
        scan_cnt_next   = scan_cnt_reg;
        pend_next       = 1'b0;
        found_next      = found_reg;
        size_next       = size_reg;
        off_next        = off_reg;
        pend_idx_next   = pend_idx_reg;
        keep_end_next   = keep_end_reg;
        res_offset_next = res_offset_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_offset_next = out_offset_reg;
        out_status_next = out_status_reg;
        out_used_next   = out_used_reg;
        next_wide       = CMP_W'(used_reg);

        if (cmd.start)
        begin
            size_next     = request_size;
            off_next      = free_offset;
            scan_cnt_next = '0;
            found_next    = 1'b0;
            keep_end_next = '0;
        end

        if (cmd.do_alloc)
        begin
            if (alloc_fail)
            begin
                res_offset_next = '0;
                res_status_next = stha_pkg::STATUS_NOMEM;
            end
            else
            begin
                res_offset_next = used_field;
                res_status_next = stha_pkg::STATUS_OK;
                used_next       = new_end[OFF_W-1:0];
                count_next      = count_reg + CNT_W'(1);
            end
        end

        if (scan_issue)
        begin
            pend_next     = 1'b1;
            pend_idx_next = scan_cnt_reg[ADDR_W-1:0];
            scan_cnt_next = scan_cnt_reg + CNT_W'(1);
        end

        // Check the entry read last cycle; remember the end of the last kept entry.
        if (pend_reg)
        begin
            if (scan_match)
            begin
                found_next = 1'b1;
            end
            else
            begin
                keep_end_next = rd_end;
            end
        end

        if (cmd.commit_free)
        begin
            res_offset_next = '0;
            if (found_reg)
            begin
                res_status_next = stha_pkg::STATUS_OK;
                used_next       = keep_end_reg;
                count_next      = count_reg - CNT_W'(1);
            end
            else
            begin
                res_status_next = stha_pkg::STATUS_NOTALLOC;
            end
        end

        if (cmd.load_out)
        begin
            out_valid_next  = 1'b1;
            out_offset_next = res_offset_reg;
            out_status_next = res_status_reg;
            out_used_next   = next_wide[stha_pkg::FIELD_W-1:0];
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            used_reg      <= '0;
            scan_cnt_reg  <= '0;
            pend_reg      <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            used_reg      <= used_next;
            scan_cnt_reg  <= scan_cnt_next;
            pend_reg      <= pend_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        size_reg       <= size_next;
        off_reg        <= off_next;
        pend_idx_reg   <= pend_idx_next;
        keep_end_reg   <= keep_end_next;
        res_offset_reg <= res_offset_next;
        res_status_reg <= res_status_next;
        out_offset_reg <= out_offset_next;
        out_status_reg <= out_status_next;
        out_used_reg   <= out_used_next;
    end

    assign out_valid    = out_valid_reg;
    assign alloc_offset = out_offset_reg;
    assign status       = out_status_reg;
    assign used_bytes   = out_used_reg;

    // Table bookkeeping checks.
    `STHA_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(TABLE_ENTRIES))
    `STHA_ASSERT_IMP(a_used_bound, clk, rst_n, 1'b1, SUM_W'(used_reg) <= SUM_W'(HEAP_BYTES))
    `STHA_ASSERT_IMP(a_empty_heap, clk, rst_n, count_reg == '0, used_reg == '0)
    `STHA_ASSERT_NXT(a_free_drops_one, clk, rst_n, cmd.commit_free && found_reg,
                     count_reg == $past(count_reg) - CNT_W'(1))

endmodule

// ----- rtl/segment_table_heap_allocator.sv -----
// Segment table heap allocator, one item at a time. An allocate passes through the ALLOC and
// FINISH states; a free passes through SCAN and FINISH, bound by the scan that reads and
// moves the table RAM one entry per cycle, so a free takes longer the more segments there are.
// The next item is taken the cycle after the result is loaded into the output register.
// Reset (rst_n, asynchronous, active low) empties the table; the table RAM is not cleared.
module segment_table_heap_allocator #(
    parameter int HEAP_BYTES    = stha_pkg::HEAP_BYTES_DEF,
    parameter int TABLE_ENTRIES = stha_pkg::TABLE_ENTRIES_DEF
) (
    input logic        clk,
    input logic        rst_n,
    stha_req_if.sink   req,
    stha_rsp_if.source rsp
);

    stha_pkg::cmd_t  cmd;
    stha_pkg::stat_t stat;

    // Sequencing of allocate and free.
    stha_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(req.valid),
        .opcode  (req.opcode),
        .in_ready(req.ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Table, heap end and result register.
    stha_dp #(
        .HEAP_BYTES   (HEAP_BYTES),
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .request_size(req.request_size),
        .free_offset (req.free_offset),
        .out_valid   (rsp.valid),
        .out_ready   (rsp.ready),
        .alloc_offset(rsp.alloc_offset),
        .status      (rsp.status),
        .used_bytes  (rsp.used_bytes)
    );

endmodule
